[rtl/core/prt_pkg.sv]
package prt_pkg;

   localparam int DATA_W  = 32;
   localparam int INDEX_W = 19;
   localparam int PROD_W  = 2 * DATA_W;
   // Wide signed intermediate that is saturated back to DATA_W.
   localparam int WIDE_W  = 52;
   // Bits of the dividend magnitude |inc * n|, which stays below 2^50.
   localparam int DIV_W   = 51;
   localparam int CNT_W   = $clog2(DIV_W);

   localparam logic [INDEX_W-1:0] ONE_Q16 = INDEX_W'(65536);

   localparam int PROG_LEN = 11;
   localparam int STEP_W   = $clog2(PROG_LEN);

   typedef logic [STEP_W-1:0] step_addr_type;

   localparam step_addr_type STEP_IDLE   = STEP_W'(0);
   localparam step_addr_type STEP_MUL_YC = STEP_W'(1);
   localparam step_addr_type STEP_INC    = STEP_W'(2);
   localparam step_addr_type STEP_MUL_IN = STEP_W'(3);
   localparam step_addr_type STEP_DIVINI = STEP_W'(4);
   localparam step_addr_type STEP_DIVSTP = STEP_W'(5);
   localparam step_addr_type STEP_QUOT   = STEP_W'(6);
   localparam step_addr_type STEP_SLOPE  = STEP_W'(7);
   localparam step_addr_type STEP_MUL_DU = STEP_W'(8);
   localparam step_addr_type STEP_FINISH = STEP_W'(9);
   localparam step_addr_type STEP_PASS   = STEP_W'(10);

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL_YC,
      OP_INC,
      OP_MUL_IN,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_QUOT,
      OP_SLOPE,
      OP_PASS,
      OP_MUL_DU,
      OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      CND_NEXT,
      CND_JUMP,
      CND_OBJ,
      CND_LOOP,
      CND_REQ,
      CND_OUT
   } cond_type;

   typedef struct packed {
      op_type        op;
      cond_type      cond;
      step_addr_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic              clip;
      logic [DATA_W-1:0] val;
   } sat_type;

   // Control store of the sequencer.
   function automatic ctrl_word_type ucode(input step_addr_type addr);
      ctrl_word_type w;
      case (addr)
         STEP_IDLE:   w = '{OP_LOAD,      CND_REQ,  STEP_IDLE};
         STEP_MUL_YC: w = '{OP_MUL_YC,    CND_NEXT, STEP_IDLE};
         STEP_INC:    w = '{OP_INC,       CND_OBJ,  STEP_PASS};
         STEP_MUL_IN: w = '{OP_MUL_IN,    CND_NEXT, STEP_IDLE};
         STEP_DIVINI: w = '{OP_DIV_INIT,  CND_NEXT, STEP_IDLE};
         STEP_DIVSTP: w = '{OP_DIV_STEP,  CND_LOOP, STEP_IDLE};
         STEP_QUOT:   w = '{OP_QUOT,      CND_NEXT, STEP_IDLE};
         STEP_SLOPE:  w = '{OP_SLOPE,     CND_NEXT, STEP_IDLE};
         STEP_MUL_DU: w = '{OP_MUL_DU,    CND_NEXT, STEP_IDLE};
         STEP_FINISH: w = '{OP_FINISH,    CND_OUT,  STEP_IDLE};
         STEP_PASS:   w = '{OP_PASS,      CND_JUMP, STEP_MUL_DU};
         default:     w = '{OP_NOP,       CND_JUMP, STEP_IDLE};
      endcase
      return w;
   endfunction

   // Clip a wide signed value to the 32-bit range.
   function automatic sat_type sat32(input logic [WIDE_W-1:0] v);
      sat_type r;
      if (v[WIDE_W-1:DATA_W-1] == '0 || v[WIDE_W-1:DATA_W-1] == '1) begin
         r.clip = 1'b0;
         r.val  = v[DATA_W-1:0];
      end else begin
         r.clip = 1'b1;
         r.val  = v[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

[rtl/core/paraxial_ray_trace_unit.sv]
// Paraxial y-n-u trace, one surface per word, run by a microcoded sequencer.
// A refracting surface runs the 51-step restoring divider for i*n/n'; an object surface
// skips it and passes its slope through. A new word is accepted only in the idle step, after
// the finish step has written the previous result; that step waits while a result is unread.
// Reset (synchronous, active high) clears the ray to height 0, slope 0, index 1.0 and
// returns the sequencer to its idle step; a waiting result is dropped.
module paraxial_ray_trace_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_object_surface,
   input  logic signed [prt_pkg::DATA_W-1:0]    req_start_height,
   input  logic signed [prt_pkg::DATA_W-1:0]    req_start_slope,
   input  logic signed [prt_pkg::DATA_W-1:0]    req_curvature,
   input  logic signed [prt_pkg::DATA_W-1:0]    req_gap_thickness,
   input  logic        [prt_pkg::INDEX_W-1:0]   req_index_after,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [prt_pkg::DATA_W-1:0]    rsp_ray_height,
   output logic signed [prt_pkg::DATA_W-1:0]    rsp_slope_after,
   output logic signed [prt_pkg::DATA_W-1:0]    rsp_incidence,
   output logic        [prt_pkg::INDEX_W-1:0]   rsp_index_out,
   output logic                                 rsp_saturated
);

   localparam int DW = prt_pkg::DATA_W;
   localparam int IW = prt_pkg::INDEX_W;
   localparam int PW = prt_pkg::PROD_W;
   localparam int VW = prt_pkg::WIDE_W;
   localparam int QW = prt_pkg::DIV_W;
   localparam int CW = prt_pkg::CNT_W;

   // Sequencer
   prt_pkg::step_addr_type pc_ff, pc_in;
   prt_pkg::ctrl_word_type cw;
   logic                   go;

   // Ray state
   logic [DW-1:0] height_ff, height_in;
   logic [DW-1:0] slope_ff, slope_in;
   logic [IW-1:0] nb_ff, nb_in;

   // Working registers
   logic [DW-1:0] y_ff, y_in, u_ff, u_in, c_ff, c_in, d_ff, d_in;
   logic [IW-1:0] np_ff, np_in;
   logic          obj_ff, obj_in;
   logic [PW-1:0] prod_ff, prod_in, yc_ff, yc_in;
   logic [DW-1:0] inc_ff, inc_in, q_ff, q_in, up_ff, up_in;
   logic          sat_ff, sat_in;

   // Divider
   logic [IW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] o_y_ff, o_y_in, o_up_ff, o_up_in, o_inc_ff, o_inc_in;
   logic [IW-1:0] o_np_ff, o_np_in;
   logic          o_sat_ff, o_sat_in;

   // Datapath arithmetic
   logic signed [DW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_p;
   logic [PW:0]          inc_sum, up_diff;
   logic [PW-1:0]        prod_abs;
   logic [VW-1:0]        quot_signed;
   logic [DW+16:0]       h_sum;
   logic [IW:0]          rem_sh;
   logic [IW+1:0]        trial;
   logic                 ge;
   prt_pkg::sat_type     s_inc, s_quot, s_up, s_h;
   logic                 accept;

   assign cw     = prt_pkg::ucode(pc_ff);
   assign accept = req_valid && req_ready;

   always_comb begin
      case (cw.cond)
         prt_pkg::CND_REQ: go = req_valid;
         prt_pkg::CND_OUT: go = !rsp_valid_ff || rsp_ready;
         default:          go = 1'b1;
      endcase
   end

   // Next step
   always_comb begin
      case (cw.cond)
         prt_pkg::CND_NEXT: pc_in = pc_ff + 1'b1;
         prt_pkg::CND_JUMP: pc_in = cw.target;
         prt_pkg::CND_OBJ:  pc_in = obj_ff ? cw.target : pc_ff + 1'b1;
         prt_pkg::CND_LOOP: pc_in = (cnt_ff != '0) ? pc_ff : pc_ff + 1'b1;
         prt_pkg::CND_REQ:  pc_in = go ? pc_ff + 1'b1 : pc_ff;
         prt_pkg::CND_OUT:  pc_in = go ? cw.target : pc_ff;
         default:           pc_in = prt_pkg::STEP_IDLE;
      endcase
   end

   // One shared signed multiplier; its product is always registered.
   always_comb begin
      case (cw.op)
         prt_pkg::OP_MUL_IN: begin
            mul_a = inc_ff;
            mul_b = $signed({{(DW-IW){1'b0}}, nb_ff});
         end
         prt_pkg::OP_MUL_DU: begin
            mul_a = d_ff;
            mul_b = up_ff;
         end
         default: begin
            mul_a = y_ff;
            mul_b = c_ff;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign inc_sum  = {{17{u_ff[DW-1]}}, u_ff, 16'b0} + {prod_ff[PW-1], prod_ff};
   assign s_inc    = prt_pkg::sat32({{3{inc_sum[PW]}}, inc_sum[PW:16]});
   assign prod_abs = prod_ff[PW-1] ? (PW'(0) - prod_ff) : prod_ff;

   assign rem_sh = {rem_ff, quo_ff[QW-1]};
   assign trial  = {1'b0, rem_sh} - {2'b0, np_ff};
   assign ge     = !trial[IW+1];

   assign quot_signed = neg_ff ? (VW'(0) - {1'b0, quo_ff}) : {1'b0, quo_ff};
   assign s_quot      = prt_pkg::sat32(quot_signed);

   assign up_diff = {{17{q_ff[DW-1]}}, q_ff, 16'b0} - {yc_ff[PW-1], yc_ff};
   assign s_up    = prt_pkg::sat32({{3{up_diff[PW]}}, up_diff[PW:16]});

   assign h_sum = {{17{y_ff[DW-1]}}, y_ff} + {prod_ff[PW-1], prod_ff[PW-1:16]};
   assign s_h   = prt_pkg::sat32({{(VW-DW-17){h_sum[DW+16]}}, h_sum});

   // Control word decode into register updates
   always_comb begin
      height_in = height_ff;
      slope_in  = slope_ff;
      nb_in     = nb_ff;
      y_in      = y_ff;
      u_in      = u_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      np_in     = np_ff;
      obj_in    = obj_ff;
      prod_in   = prod_ff;
      yc_in     = yc_ff;
      inc_in    = inc_ff;
      q_in      = q_ff;
      up_in     = up_ff;
      sat_in    = sat_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      o_y_in    = o_y_ff;
      o_up_in   = o_up_ff;
      o_inc_in  = o_inc_ff;
      o_np_in   = o_np_ff;
      o_sat_in  = o_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (cw.op)
         prt_pkg::OP_LOAD: begin
            if (go) begin
               obj_in = req_object_surface;
               y_in   = req_object_surface ? req_start_height : height_ff;
               u_in   = req_object_surface ? req_start_slope : slope_ff;
               c_in   = req_curvature;
               d_in   = req_gap_thickness;
               // A zero index is taken as 1.0.
               np_in  = (req_index_after == '0) ? prt_pkg::ONE_Q16 : req_index_after;
               sat_in = 1'b0;
            end
         end
         prt_pkg::OP_MUL_YC, prt_pkg::OP_MUL_IN, prt_pkg::OP_MUL_DU: begin
            prod_in = mul_p;
         end
         prt_pkg::OP_INC: begin
            yc_in  = prod_ff;
            inc_in = s_inc.val;
            sat_in = sat_ff | s_inc.clip;
         end
         prt_pkg::OP_DIV_INIT: begin
            neg_in = prod_ff[PW-1];
            quo_in = prod_abs[QW-1:0];
            rem_in = '0;
            cnt_in = CW'(QW - 1);
         end
         prt_pkg::OP_DIV_STEP: begin
            rem_in = ge ? trial[IW-1:0] : rem_sh[IW-1:0];
            quo_in = {quo_ff[QW-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
         end
         prt_pkg::OP_QUOT: begin
            q_in   = s_quot.val;
            sat_in = sat_ff | s_quot.clip;
         end
         prt_pkg::OP_SLOPE: begin
            up_in  = s_up.val;
            sat_in = sat_ff | s_up.clip;
         end
         prt_pkg::OP_PASS: begin
            up_in = u_ff;
         end
         prt_pkg::OP_FINISH: begin
            if (go) begin
               height_in    = s_h.val;
               slope_in     = up_ff;
               nb_in        = np_ff;
               o_y_in       = y_ff;
               o_up_in      = up_ff;
               o_inc_in     = inc_ff;
               o_np_in      = np_ff;
               o_sat_in     = sat_ff | s_h.clip;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= prt_pkg::STEP_IDLE;
         height_ff    <= '0;
         slope_ff     <= '0;
         nb_ff        <= prt_pkg::ONE_Q16;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         pc_ff        <= pc_in;
         height_ff    <= height_in;
         slope_ff     <= slope_in;
         nb_ff        <= nb_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff     <= y_in;
      u_ff     <= u_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      np_ff    <= np_in;
      obj_ff   <= obj_in;
      prod_ff  <= prod_in;
      yc_ff    <= yc_in;
      inc_ff   <= inc_in;
      q_ff     <= q_in;
      up_ff    <= up_in;
      sat_ff   <= sat_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      neg_ff   <= neg_in;
      o_y_ff   <= o_y_in;
      o_up_ff  <= o_up_in;
      o_inc_ff <= o_inc_in;
      o_np_ff  <= o_np_in;
      o_sat_ff <= o_sat_in;
   end

   assign req_ready       = (pc_ff == prt_pkg::STEP_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ray_height  = o_y_ff;
   assign rsp_slope_after = o_up_ff;
   assign rsp_incidence   = o_inc_ff;
   assign rsp_index_out   = o_np_ff;
   assign rsp_saturated   = o_sat_ff;

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      pc_ff < prt_pkg::step_addr_type'(prt_pkg::PROG_LEN))
      else $error("sequencer left the control store");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> pc_ff == prt_pkg::STEP_MUL_YC)
      else $error("accepted word did not start the program");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == prt_pkg::STEP_DIVSTP) |-> rem_ff < np_ff)
      else $error("divider remainder not below divisor");

   a_index_nonzero: assert property (@(posedge clock) disable iff (reset)
      nb_ff != '0)
      else $error("held index is zero");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc_ff) == prt_pkg::STEP_FINISH)
      else $error("result word appeared outside the finish step");

endmodule
